### src/vgcd_pkg.sv
// Shared constants and types for the volume gradient block.
// No dependencies; every other file of the block but vgcd_ram uses this package.
package vgcd_pkg;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int MAX_Z = 1024;

  // Coordinate widths and widths of the effective dimensions (which can hold the maximum).
  localparam int X_W  = $clog2(MAX_X);
  localparam int Y_W  = $clog2(MAX_Y);
  localparam int Z_W  = $clog2(MAX_Z);
  localparam int DX_W = $clog2(MAX_X + 1);
  localparam int DY_W = $clog2(MAX_Y + 1);
  localparam int DZ_W = $clog2(MAX_Z + 1);

  localparam int VOX_W  = 8;
  localparam int GRAD_W = 10;

  // Configuration port: raw register widths as written.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIMX_REG_W = 7;
  localparam int DIMY_REG_W = 7;
  localparam int DIMZ_REG_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = CFG_IDX_W'(2);

  localparam int DIM_X_RESET = 64;
  localparam int DIM_Y_RESET = 64;
  localparam int DIM_Z_RESET = 64;

  localparam logic KIND_VOXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Two planes of history, selected by z parity.
  localparam int HIST_DEPTH = 2 * MAX_X * MAX_Y;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  // Job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  // What the front decides for one result.
  typedef struct packed {
    logic             xlo;
    logic             xhi;
    logic             ylo;
    logic             yhi;
    logic             zlo;
    logic             zhi_in;
    logic [VOX_W-1:0] zhi;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [Z_W-1:0]   z;
    logic             fin;
  } meta_t;

  // One queued job: decision plus neighbor samples from history.
  typedef struct packed {
    meta_t            meta;
    logic [VOX_W-1:0] vxl;
    logic [VOX_W-1:0] vxh;
    logic [VOX_W-1:0] vyl;
    logic [VOX_W-1:0] vyh;
    logic [VOX_W-1:0] vzl;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

### src/vgcd_if.sv
// Channel interfaces of the volume gradient block: samples, results, configuration.
// Depends on vgcd_pkg.
interface vgcd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [vgcd_pkg::VOX_W-1:0]  voxel_value;

  modport source (output valid, kind, voxel_value, input ready);
  modport sink   (input valid, kind, voxel_value, output ready);
endinterface

interface vgcd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vgcd_pkg::GRAD_W-1:0] grad_x;
  logic signed [vgcd_pkg::GRAD_W-1:0] grad_y;
  logic signed [vgcd_pkg::GRAD_W-1:0] grad_z;
  logic [vgcd_pkg::X_W-1:0]           pos_x;
  logic [vgcd_pkg::Y_W-1:0]           pos_y;
  logic [vgcd_pkg::Z_W-1:0]           pos_z;
  logic                               last;

  modport source (output valid, grad_x, grad_y, grad_z, pos_x, pos_y, pos_z, last,
                  input ready);
  modport sink   (input valid, grad_x, grad_y, grad_z, pos_x, pos_y, pos_z, last,
                  output ready);
endinterface

interface vgcd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vgcd_pkg::CFG_IDX_W-1:0]    index;
  logic [vgcd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/vgcd_ram.sv
// Generic RAM: one write port, two read ports, registered read (old data on collision).
// No dependencies.
module vgcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### src/vgcd_front.sv
// Front part: configuration, sample acceptance, position counters, plane history.
// Depends on vgcd_pkg, vgcd_if and vgcd_ram.
module vgcd_front (
  input  logic                      clk,
  input  logic                      rst,
  vgcd_in_if.sink                   vox,
  vgcd_cfg_if.sink                  cfg,
  input  logic [vgcd_pkg::QLVL_W-1:0] q_level,
  output vgcd_pkg::push_t           push
);
  import vgcd_pkg::*;

  function automatic logic [CFG_DATA_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                       input int maxv);
    logic [CFG_DATA_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_DATA_W'(1);
    end else if (int'(v) > maxv) begin
      r = CFG_DATA_W'(maxv);
    end
    return r;
  endfunction

  logic [DX_W-1:0] dim_x;
  logic [DY_W-1:0] dim_y;
  logic [DZ_W-1:0] dim_z;

  logic [X_W-1:0] arrive_x, arrive_x_next, emit_x, emit_x_next;
  logic [Y_W-1:0] arrive_y, arrive_y_next, emit_y, emit_y_next;
  logic [Z_W-1:0] arrive_z, arrive_z_next, emit_z, emit_z_next;
  logic           done, done_next;

  logic           s1_valid;
  meta_t          s1_meta;
  meta_t          meta;

  logic           acc, emit_now, wr_now;
  logic           a_xin, a_yin, a_zin, e_xin, e_yin, e_zin, fin;
  logic [QLVL_W-1:0] occ;

  logic [HIST_AW-1:0] wr_addr, a_xl, a_xh, a_yl, a_yh, a_zl;
  logic [VOX_W-1:0]   d_xl, d_xh, d_yl, d_yh, d_zl;

  // One slot for the job in flight through the history read.
  assign occ       = q_level + QLVL_W'(s1_valid);
  assign vox.ready = occ < QLVL_W'(QDEPTH);
  assign acc       = vox.valid && vox.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    a_xin = (DX_W'(arrive_x) + DX_W'(1)) < dim_x;
    a_yin = (DY_W'(arrive_y) + DY_W'(1)) < dim_y;
    a_zin = (DZ_W'(arrive_z) + DZ_W'(1)) < dim_z;
    e_xin = (DX_W'(emit_x) + DX_W'(1)) < dim_x;
    e_yin = (DY_W'(emit_y) + DY_W'(1)) < dim_y;
    e_zin = (DZ_W'(emit_z) + DZ_W'(1)) < dim_z;
    fin   = !e_xin && !e_yin && !e_zin;

    if (vox.kind == KIND_FLUSH) begin
      emit_now = acc && done;
      wr_now   = 1'b0;
    end else begin
      emit_now = acc && !done && (arrive_z != '0);
      wr_now   = acc && !done;
    end

    meta.xlo    = emit_x != '0;
    meta.xhi    = e_xin;
    meta.ylo    = emit_y != '0;
    meta.yhi    = e_yin;
    meta.zlo    = emit_z != '0;
    meta.zhi_in = vox.kind == KIND_VOXEL;
    meta.zhi    = vox.voxel_value;
    meta.x      = emit_x;
    meta.y      = emit_y;
    meta.z      = emit_z;
    meta.fin    = fin;

    arrive_x_next = arrive_x;
    arrive_y_next = arrive_y;
    arrive_z_next = arrive_z;
    emit_x_next   = emit_x;
    emit_y_next   = emit_y;
    emit_z_next   = emit_z;
    done_next     = done;

    // Advance the result position; the final one wraps and reopens the volume.
    if (emit_now) begin
      if (fin) begin
        emit_x_next = '0;
        emit_y_next = '0;
        emit_z_next = '0;
        done_next   = 1'b0;
      end else if (e_xin) begin
        emit_x_next = emit_x + X_W'(1);
      end else begin
        emit_x_next = '0;
        if (e_yin) begin
          emit_y_next = emit_y + Y_W'(1);
        end else begin
          emit_y_next = '0;
          emit_z_next = e_zin ? emit_z + Z_W'(1) : '0;
        end
      end
    end

    // Advance the arrival position; wrapping the whole volume starts the flush.
    if (wr_now) begin
      if (a_xin) begin
        arrive_x_next = arrive_x + X_W'(1);
      end else begin
        arrive_x_next = '0;
        if (a_yin) begin
          arrive_y_next = arrive_y + Y_W'(1);
        end else begin
          arrive_y_next = '0;
          if (a_zin) begin
            arrive_z_next = arrive_z + Z_W'(1);
          end else begin
            arrive_z_next = '0;
            done_next     = 1'b1;
          end
        end
      end
    end
  end

  // History slot is {z parity, y, x}.
  assign wr_addr = {arrive_z[0], arrive_y, arrive_x};
  assign a_xl    = {emit_z[0], emit_y, emit_x - X_W'(1)};
  assign a_xh    = {emit_z[0], emit_y, emit_x + X_W'(1)};
  assign a_yl    = {emit_z[0], emit_y - Y_W'(1), emit_x};
  assign a_yh    = {emit_z[0], emit_y + Y_W'(1), emit_x};
  assign a_zl    = {~emit_z[0], emit_y, emit_x};

  // Three copies of the history give five reads a cycle; all take the same write.
  vgcd_ram #(.WIDTH(VOX_W), .DEPTH(HIST_DEPTH)) u_hist_x (
    .clk(clk), .wr_en(wr_now), .wr_addr(wr_addr), .wr_data(vox.voxel_value),
    .rd_addr_a(a_xl), .rd_data_a(d_xl), .rd_addr_b(a_xh), .rd_data_b(d_xh)
  );

  vgcd_ram #(.WIDTH(VOX_W), .DEPTH(HIST_DEPTH)) u_hist_y (
    .clk(clk), .wr_en(wr_now), .wr_addr(wr_addr), .wr_data(vox.voxel_value),
    .rd_addr_a(a_yl), .rd_data_a(d_yl), .rd_addr_b(a_yh), .rd_data_b(d_yh)
  );

  vgcd_ram #(.WIDTH(VOX_W), .DEPTH(HIST_DEPTH)) u_hist_z (
    .clk(clk), .wr_en(wr_now), .wr_addr(wr_addr), .wr_data(vox.voxel_value),
    .rd_addr_a(a_zl), .rd_data_a(d_zl), .rd_addr_b(a_zl), .rd_data_b()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x    <= DX_W'(DIM_X_RESET);
      dim_y    <= DY_W'(DIM_Y_RESET);
      dim_z    <= DZ_W'(DIM_Z_RESET);
      arrive_x <= '0;
      arrive_y <= '0;
      arrive_z <= '0;
      emit_x   <= '0;
      emit_y   <= '0;
      emit_z   <= '0;
      done     <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_DIM_X: dim_x <= DX_W'(clamp_dim(CFG_DATA_W'(cfg.data[DIMX_REG_W-1:0]), MAX_X));
          CFG_DIM_Y: dim_y <= DY_W'(clamp_dim(CFG_DATA_W'(cfg.data[DIMY_REG_W-1:0]), MAX_Y));
          CFG_DIM_Z: dim_z <= DZ_W'(clamp_dim(CFG_DATA_W'(cfg.data[DIMZ_REG_W-1:0]), MAX_Z));
          default: ;
        endcase
      end
      arrive_x <= arrive_x_next;
      arrive_y <= arrive_y_next;
      arrive_z <= arrive_z_next;
      emit_x   <= emit_x_next;
      emit_y   <= emit_y_next;
      emit_z   <= emit_z_next;
      done     <= done_next;
      s1_valid <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      s1_meta <= meta;
    end
  end

  always_comb begin
    push.valid    = s1_valid;
    push.job.meta = s1_meta;
    push.job.vxl  = d_xl;
    push.job.vxh  = d_xh;
    push.job.vyl  = d_yl;
    push.job.vyh  = d_yh;
    push.job.vzl  = d_zl;
  end

endmodule

### src/vgcd_queue.sv
// Short job queue between the front and back parts.
// Depends on vgcd_pkg. The front never pushes into a full queue.
module vgcd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  vgcd_pkg::push_t             push,
  input  logic                        pop,
  output logic                        q_valid,
  output vgcd_pkg::job_t              head,
  output logic [vgcd_pkg::QLVL_W-1:0] level
);
  import vgcd_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QLVL_W-1:0] count;

  assign q_valid = count != '0;
  assign head    = slots[rd_ptr];
  assign level   = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QLVL_W'(push.valid) - QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.job;
    end
  end

endmodule

### src/vgcd_back.sv
// Back part: central differences from queued jobs into the result register.
// Depends on vgcd_pkg and vgcd_if.
module vgcd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  vgcd_pkg::job_t head,
  output logic           pop,
  vgcd_out_if.source     grad
);
  import vgcd_pkg::*;

  // Negated central difference in halves; an outside neighbor reads 0 and doubles.
  function automatic logic [GRAD_W-1:0] axis_grad(input logic lo_in, input logic [VOX_W-1:0] lo,
                                                  input logic hi_in, input logic [VOX_W-1:0] hi);
    logic [GRAD_W-1:0] f1, f2, d;
    f1 = lo_in ? GRAD_W'(lo) : '0;
    f2 = hi_in ? GRAD_W'(hi) : '0;
    d  = f1 - f2;
    if (!(lo_in && hi_in)) begin
      d = {d[GRAD_W-2:0], 1'b0};
    end
    return d;
  endfunction

  logic              out_valid;
  logic [GRAD_W-1:0] gx, gy, gz;
  logic [X_W-1:0]    px;
  logic [Y_W-1:0]    py;
  logic [Z_W-1:0]    pz;
  logic              plast;

  assign pop = q_valid && (!out_valid || grad.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || grad.ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      gx    <= axis_grad(head.meta.xlo, head.vxl, head.meta.xhi, head.vxh);
      gy    <= axis_grad(head.meta.ylo, head.vyl, head.meta.yhi, head.vyh);
      gz    <= axis_grad(head.meta.zlo, head.vzl, head.meta.zhi_in, head.meta.zhi);
      px    <= head.meta.x;
      py    <= head.meta.y;
      pz    <= head.meta.z;
      plast <= head.meta.fin;
    end
  end

  assign grad.valid  = out_valid;
  assign grad.grad_x = signed'(gx);
  assign grad.grad_y = signed'(gy);
  assign grad.grad_z = signed'(gz);
  assign grad.pos_x  = px;
  assign grad.pos_y  = py;
  assign grad.pos_z  = pz;
  assign grad.last   = plast;

endmodule

### src/volume_gradient_central_difference.sv
// Top level of the streaming 3-D central-difference gradient block.
// Depends on vgcd_pkg, vgcd_if, vgcd_front, vgcd_queue, vgcd_back.
//
//   channel  role    payload                                    transfer when
//   vox      sink    kind, voxel_value                          valid & ready
//   grad     source  grad_x/y/z, pos_x/y/z, last                valid & ready
//   cfg      sink    index (0 dim_x, 1 dim_y, 2 dim_z), data    valid & ready
//
// One sample per cycle while grad is not stalled. A result passes through
// the history read, the job queue and the result register after the
// transfer that causes it.
// Reset (rst, synchronous) clears counters, queue and result register and sets
// all dimensions to 64; the plane history needs no clearing pass.
// A stall on grad fills the four-entry job queue; vox drops ready only once
// the queue and the job in flight through the history read use every slot.
// cfg is always ready.
module volume_gradient_central_difference (
  input  logic        clk,
  input  logic        rst,
  vgcd_in_if.sink     vox,
  vgcd_out_if.source  grad,
  vgcd_cfg_if.sink    cfg
);
  import vgcd_pkg::*;

  push_t             push;
  job_t              head;
  logic              q_valid;
  logic              pop;
  logic [QLVL_W-1:0] q_level;

  // Front: accept samples and flush items, decide whether a result is due,
  // keep the two planes of history and read the five stored neighbors.
  vgcd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .vox     (vox),
    .cfg     (cfg),
    .q_level (q_level),
    .push    (push)
  );

  // Queue: decouple the history read from the result handshake.
  vgcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (pop),
    .q_valid (q_valid),
    .head    (head),
    .level   (q_level)
  );

  // Back: form the three differences and hold the result until transfer.
  vgcd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .grad    (grad)
  );

endmodule

### src/vgcd_chk.sv
// Port-level checks for the volume gradient block, bound to the top level.
// Depends on vgcd_pkg.
module vgcd_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              grad_valid,
  input logic                              grad_ready,
  input logic signed [vgcd_pkg::GRAD_W-1:0] grad_x,
  input logic signed [vgcd_pkg::GRAD_W-1:0] grad_z,
  input logic [vgcd_pkg::X_W-1:0]          pos_x,
  input logic [vgcd_pkg::Z_W-1:0]          pos_z
);
  import vgcd_pkg::*;

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    grad_valid && !grad_ready |=> grad_valid)
    else $error("result dropped while stalled");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !grad_valid)
    else $error("result offered after reset");

  // At x = 0 the low neighbor is outside, so the x difference is doubled.
  a_x_edge_even: assert property (@(posedge clk) disable iff (rst)
    grad_valid && pos_x == '0 |-> !grad_x[0])
    else $error("odd x gradient at the x = 0 face");

  // In the first plane the z difference is doubled.
  a_z_edge_even: assert property (@(posedge clk) disable iff (rst)
    grad_valid && pos_z == '0 |-> !grad_z[0])
    else $error("odd z gradient in the first plane");

endmodule

bind volume_gradient_central_difference vgcd_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .grad_valid (grad.valid),
  .grad_ready (grad.ready),
  .grad_x     (grad.grad_x),
  .grad_z     (grad.grad_z),
  .pos_x      (grad.pos_x),
  .pos_z      (grad.pos_z)
);

### test/tb_volume_gradient_central_difference.sv
`timescale 1ns / 1ps
// Self-checking testbench for volume_gradient_central_difference.
// Depends on vgcd_pkg, the vgcd channel interfaces and the block's RTL.
module tb_volume_gradient_central_difference;
  import vgcd_pkg::*;

  localparam int ITEM_COUNT = 1200;      // voxel and flush transfers that count
  localparam int SETTLE_CYCLES = 8;      // pipeline latency plus margin
  localparam int END_WAIT_LIMIT = 20000;
  localparam int TIMEOUT_NS = 4_000_000;
  localparam int EXTREME_COUNT = 3;
  localparam int DEPTH_CORNER_ITEMS = MAX_Z + 1;  // 1x1 column at full depth plus its flush
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);  // index with no register

  // One gradient result as the grad channel carries it.
  typedef struct {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gz;
    logic [X_W-1:0]           px;
    logic [Y_W-1:0]           py;
    logic [Z_W-1:0]           pz;
    logic                     last;
  } grad_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

  // One line of the directed table: a sample/flush transfer or a register write.
  typedef struct {
    row_op_e                op;
    logic                   kind;
    logic [VOX_W-1:0]       value;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     typed;
    grad_res_t              want;
  } stim_row_t;

  logic clk;
  logic rst;

  vgcd_in_if  vox();
  vgcd_out_if grad();
  vgcd_cfg_if cfg();

  volume_gradient_central_difference DUT (
    .clk  (clk),
    .rst  (rst),
    .vox  (vox),
    .grad (grad),
    .cfg  (cfg)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Gradient predictor: raw dimension registers, two planes of voxel history
  // selected by z parity, the arrival and emit cursors and the flush flag.
  // ---------------------------------------------------------------------------
  logic [DIMX_REG_W-1:0] dimx_reg;
  logic [DIMY_REG_W-1:0] dimy_reg;
  logic [DIMZ_REG_W-1:0] dimz_reg;
  logic [VOX_W-1:0]      plane_mem [HIST_DEPTH];
  int                    in_x, in_y, in_z;
  int                    out_x, out_y, out_z;
  bit                    vol_complete;   // whole volume arrived, final plane pending

  grad_res_t pending_grads[$];   // predicted results not yet seen on grad
  stim_row_t directed_rows[$];
  grad_res_t no_want;
  int        error_count;
  int        accepted_items;
  int        calm_items;
  bit        calm_tail;            // last part of the run: no idling on either side

  // A zero register acts as 1, anything above the maximum acts as the maximum.
  function automatic int eff_dim(int raw, int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic int hist_slot(int z, int y, int x);
    return ((z % 2) * MAX_Y + (y % MAX_Y)) * MAX_X + (x % MAX_X);
  endfunction

  // Negated central difference in halves; a missing neighbor reads as zero
  // and doubles the result, since that axis then divides by one.
  function automatic logic signed [GRAD_W-1:0] neg_diff(bit lo_in, int lo, bit hi_in, int hi);
    int d;
    d = (lo_in ? lo : 0) - (hi_in ? hi : 0);
    if (!(lo_in && hi_in)) d = d * 2;
    return GRAD_W'(d);
  endfunction

  // Result at the emit cursor, then advance the cursor.
  function automatic grad_res_t next_gradient(bit zhi_in, int zhi);
    int        dx, dy, dz, x, y, z;
    bit        xlo, xhi, ylo, yhi, zlo, fin;
    grad_res_t r;
    dx = eff_dim(int'(dimx_reg), MAX_X);
    dy = eff_dim(int'(dimy_reg), MAX_Y);
    dz = eff_dim(int'(dimz_reg), MAX_Z);
    x = out_x;
    y = out_y;
    z = out_z;
    xlo = x > 0;
    xhi = x + 1 < dx;
    ylo = y > 0;
    yhi = y + 1 < dy;
    zlo = z > 0;
    fin = (x + 1 >= dx) && (y + 1 >= dy) && (z + 1 >= dz);
    r.gx = neg_diff(xlo, xlo ? int'(plane_mem[hist_slot(z, y, x - 1)]) : 0,
                    xhi, xhi ? int'(plane_mem[hist_slot(z, y, x + 1)]) : 0);
    r.gy = neg_diff(ylo, ylo ? int'(plane_mem[hist_slot(z, y - 1, x)]) : 0,
                    yhi, yhi ? int'(plane_mem[hist_slot(z, y + 1, x)]) : 0);
    r.gz = neg_diff(zlo, zlo ? int'(plane_mem[hist_slot(z - 1, y, x)]) : 0, zhi_in, zhi);
    r.px = X_W'(x);
    r.py = Y_W'(y);
    r.pz = Z_W'(z);
    r.last = fin;
    if (fin) begin
      out_x = 0;
      out_y = 0;
      out_z = 0;
      vol_complete = 0;
    end else if (x + 1 < dx) begin
      out_x = x + 1;
    end else begin
      out_x = 0;
      if (y + 1 < dy) begin
        out_y = y + 1;
      end else begin
        out_y = 0;
        out_z = (z + 1 < dz) ? z + 1 : 0;
      end
    end
    return r;
  endfunction

  // Apply one accepted transfer; returns 1 when it releases a result.
  function automatic bit predict_item(logic kind, logic [VOX_W-1:0] v, output grad_res_t r);
    int dx, dy, dz;
    bit got;
    got = 0;
    if (kind == KIND_FLUSH) begin
      if (!vol_complete) return 0;      // early or surplus flush
      r = next_gradient(1'b0, 0);
      return 1;
    end
    if (vol_complete) return 0;         // sample after the volume end
    dx = eff_dim(int'(dimx_reg), MAX_X);
    dy = eff_dim(int'(dimy_reg), MAX_Y);
    dz = eff_dim(int'(dimz_reg), MAX_Z);
    // The arriving sample is the z+1 neighbor of the voxel one plane back.
    if (in_z > 0) begin
      r = next_gradient(1'b1, int'(v));
      got = 1;
    end
    plane_mem[hist_slot(in_z, in_y, in_x)] = v;
    if (in_x + 1 < dx) begin
      in_x++;
    end else begin
      in_x = 0;
      if (in_y + 1 < dy) begin
        in_y++;
      end else begin
        in_y = 0;
        if (in_z + 1 < dz) begin
          in_z++;
        end else begin
          in_z = 0;
          vol_complete = 1;
        end
      end
    end
    return got;
  endfunction

  function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DIM_X: dimx_reg = data[DIMX_REG_W-1:0];
      CFG_DIM_Y: dimy_reg = data[DIMY_REG_W-1:0];
      CFG_DIM_Z: dimz_reg = data[DIMZ_REG_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every grad transfer pops the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    grad_res_t want;
    if (!rst && grad.valid && grad.ready) begin
      if (pending_grads.size() == 0) begin
        $error("unexpected result at pos %0d,%0d,%0d", grad.pos_x, grad.pos_y, grad.pos_z);
        error_count++;
      end else begin
        want = pending_grads.pop_front();
        check_field("grad_x", int'(want.gx), int'(grad.grad_x));
        check_field("grad_y", int'(want.gy), int'(grad.grad_y));
        check_field("grad_z", int'(want.gz), int'(grad.grad_z));
        check_field("pos_x", int'(want.px), int'(grad.pos_x));
        check_field("pos_y", int'(want.py), int'(grad.pos_y));
        check_field("pos_z", int'(want.pz), int'(grad.pos_z));
        check_field("last", int'(want.last), int'(grad.last));
      end
    end
  end

  // Result sink: long ready stretches broken by stalls of random length;
  // hold ready high for the whole tail of the run.
  initial begin
    forever begin
      grad.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm_tail) begin
        grad.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Source idling: gaps of random length, each followed by a run of
  // back-to-back transfers; none once the tail starts.
  task automatic source_gap();
    if (calm_tail) return;
    if (calm_items > 0) begin
      calm_items--;
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      vox.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      calm_items = $urandom_range(0, 24);
    end
  endtask

  // Drive one item and hold it until the transfer; valid stays high so the
  // next item can follow in the very next cycle.
  task automatic send_item(logic kind, logic [VOX_W-1:0] v, bit typed, grad_res_t want);
    grad_res_t r;
    bit        got;
    source_gap();
    vox.valid       <= 1'b1;
    vox.kind        <= kind;
    vox.voxel_value <= v;
    @(posedge clk);
    while (!vox.ready) @(posedge clk);
    got = predict_item(kind, v, r);
    if (typed) pending_grads.insert(pending_grads.size(), want);
    else if (got) pending_grads.insert(pending_grads.size(), r);
  endtask

  // Let every predicted result drain, then let the pipeline go quiet.
  task automatic settle();
    vox.valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    set_register(idx, data);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [VOX_W-1:0] pick_voxel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return VOX_W'($urandom);
    endcase
  endfunction

  // Garbage in the upper data bits of the narrow registers must be dropped.
  function automatic logic [CFG_DATA_W-1:0] narrow_data(int raw, int width);
    return CFG_DATA_W'(raw) | (CFG_DATA_W'($urandom) << width);
  endfunction

  // One whole volume: program the dimensions, stream the samples until the
  // last one arrives, then flush out the final plane. Stray flushes during
  // the samples and stray samples during the flush are mixed in; the block
  // must ignore them.
  task automatic run_volume(int rx, int ry, int rz);
    write_reg(CFG_DIM_X, narrow_data(rx, DIMX_REG_W));
    write_reg(CFG_DIM_Y, narrow_data(ry, DIMY_REG_W));
    write_reg(CFG_DIM_Z, CFG_DATA_W'(rz));
    while (!vol_complete) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(KIND_FLUSH, pick_voxel(), 1'b0, no_want);
      end else begin
        send_item(KIND_VOXEL, pick_voxel(), 1'b0, no_want);
        accepted_items++;
      end
    end
    while (vol_complete) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(KIND_VOXEL, pick_voxel(), 1'b0, no_want);
      end else begin
        send_item(KIND_FLUSH, pick_voxel(), 1'b0, no_want);
        accepted_items++;
      end
    end
    if ($urandom_range(0, 3) == 0) send_item(KIND_FLUSH, pick_voxel(), 1'b0, no_want);
  endtask

  // Corner dimensions: all registers zero, width above the maximum on a
  // zero-height row of two planes, height above the maximum. The depth
  // corner runs as the tail.
  task automatic extreme_dims(int k, output int rx, output int ry, output int rz);
    case (k)
      0:       begin rx = 0;   ry = 0;   rz = 0;    end
      1:       begin rx = 127; ry = 0;   rz = 2;    end
      default: begin rx = 1;   ry = 127; rz = 1;    end
    endcase
  endtask

  task automatic random_dims(output int rx, output int ry, output int rz);
    if ($urandom_range(0, 7) == 0) begin
      rx = $urandom_range(65, 127);
      ry = $urandom_range(0, 2);
      rz = $urandom_range(0, 2);
    end else begin
      do begin
        rx = $urandom_range(0, 7);
        ry = $urandom_range(0, 7);
        rz = $urandom_range(0, 6);
      end while (eff_dim(rx, MAX_X) * eff_dim(ry, MAX_Y) * eff_dim(rz, MAX_Z) > 200);
    end
  endtask

  task automatic add_item(logic kind, logic [VOX_W-1:0] v);
    stim_row_t row;
    row.op    = ROW_ITEM;
    row.kind  = kind;
    row.value = v;
    row.typed = 0;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_checked(logic kind, logic [VOX_W-1:0] v, int gx, int gy, int gz,
                             int px, int py, int pz, logic last);
    stim_row_t row;
    row.op        = ROW_ITEM;
    row.kind      = kind;
    row.value     = v;
    row.typed     = 1;
    row.want.gx   = GRAD_W'(gx);
    row.want.gy   = GRAD_W'(gy);
    row.want.gz   = GRAD_W'(gz);
    row.want.px   = X_W'(px);
    row.want.py   = Y_W'(py);
    row.want.pz   = Z_W'(pz);
    row.want.last = last;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.op   = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int rx, ry, rz;
    int ext;
    int phase;
    int waited;

    // Known levels on every input from time zero.
    rst             <= 1'b1;
    vox.valid       <= 1'b0;
    vox.kind        <= KIND_VOXEL;
    vox.voxel_value <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= CFG_DIM_X;
    cfg.data        <= '0;

    dimx_reg       = DIMX_REG_W'(DIM_X_RESET);
    dimy_reg       = DIMY_REG_W'(DIM_Y_RESET);
    dimz_reg       = DIMZ_REG_W'(DIM_Z_RESET);
    in_x           = 0;
    in_y           = 0;
    in_z           = 0;
    out_x          = 0;
    out_y          = 0;
    out_z          = 0;
    vol_complete   = 0;
    error_count    = 0;
    accepted_items = 0;
    calm_items     = 0;
    calm_tail      = 0;

    // Directed table.
    // A flush straight after reset finds no finished volume: no result.
    add_item(KIND_FLUSH, 8'hA5);
    // 1x1x2 volume from zero registers (x and y act as 1). Both samples at
    // full scale: every z difference has a missing neighbor, so the extremes
    // -510 and +510 show up, and x/y have no neighbors at all.
    add_cfg(CFG_DIM_X, '0);
    add_cfg(CFG_DIM_Y, '0);
    add_cfg(CFG_DIM_Z, CFG_DATA_W'(2));
    add_item(KIND_VOXEL, 8'hFF);
    add_checked(KIND_VOXEL, 8'hFF, 0, 0, -510, 0, 0, 0, 1'b0);
    // Sample after the volume end: ignored.
    add_item(KIND_VOXEL, 8'h5A);
    add_checked(KIND_FLUSH, 8'h00, 0, 0, 510, 0, 0, 1, 1'b1);
    // Surplus flush after the final result: ignored.
    add_item(KIND_FLUSH, 8'hFF);
    // Write to an index with no register behind it.
    add_cfg(CFG_SPARE, '1);
    // 2x2x3 volume with junk in the upper width bits; the depth drops to 2
    // after two planes, so the third plane ends the volume early and the
    // flush walks both history planes again from the origin.
    add_cfg(CFG_DIM_X, 11'h782);
    add_cfg(CFG_DIM_Y, CFG_DATA_W'(2));
    add_cfg(CFG_DIM_Z, CFG_DATA_W'(3));
    add_item(KIND_VOXEL, 8'h00);
    add_item(KIND_VOXEL, 8'hFF);
    add_item(KIND_VOXEL, 8'hFF);
    add_item(KIND_VOXEL, 8'h00);
    add_item(KIND_VOXEL, 8'h11);
    add_item(KIND_VOXEL, 8'hC8);
    add_item(KIND_VOXEL, 8'hFF);
    add_item(KIND_VOXEL, 8'h00);
    add_cfg(CFG_DIM_Z, CFG_DATA_W'(2));
    add_item(KIND_VOXEL, 8'h80);
    add_item(KIND_VOXEL, 8'h40);
    add_item(KIND_VOXEL, 8'h01);
    add_item(KIND_VOXEL, 8'hFE);
    repeat (8) add_item(KIND_FLUSH, 8'h00);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_item(directed_rows[i].kind, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Random volumes, with a corner-dimension volume every other phase until
    // all corners have run; leave room for the depth corner in the tail.
    ext = 0;
    phase = 0;
    while (accepted_items < ITEM_COUNT - DEPTH_CORNER_ITEMS || ext < EXTREME_COUNT) begin
      if (phase % 2 == 0 && ext < EXTREME_COUNT) begin
        extreme_dims(ext, rx, ry, rz);
        ext++;
      end else begin
        random_dims(rx, ry, rz);
      end
      run_volume(rx, ry, rz);
      phase++;
    end

    // Tail at full rate on both sides: depth above the maximum on a 1x1
    // column, so the z counter runs through every plane.
    calm_tail = 1;
    run_volume(1, 1, 2047);

    // Drain, with a bound, then give the pipeline its latency.
    vox.valid <= 1'b0;
    waited = 0;
    while (pending_grads.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_grads.size() != 0) begin
      $error("%0d predicted results never arrived", pending_grads.size());
      error_count++;
    end

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
src/vgcd_pkg.sv
src/vgcd_if.sv
src/vgcd_ram.sv
src/vgcd_front.sv
src/vgcd_queue.sv
src/vgcd_back.sv
src/volume_gradient_central_difference.sv
src/vgcd_chk.sv
test/tb_volume_gradient_central_difference.sv
